// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the scanner modules.
// Every macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge.
`define RAS_ASSERT(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// If the antecedent holds, the consequent holds in the same cycle.
`define RAS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// If the antecedent holds, the consequent holds in the next cycle.
`define RAS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/ras_pkg.sv -----
// Shared types and constants for the RADIUS attribute scanner.
// Used by ras_core, ras_oq and radius_attribute_scanner; depends on nothing.
package ras_pkg;

   localparam int HDR_BYTES        = 20;
   localparam int MAX_PACKET_BYTES = 4096;
   localparam int POS_W            = 17;
   localparam int OQ_DEPTH         = 4;

   localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};
   localparam logic [POS_W-1:0] HDR_LAST  = POS_W'(HDR_BYTES - 1);
   localparam logic [POS_W-1:0] HDR_COUNT = POS_W'(HDR_BYTES);
   localparam logic [15:0]      MAX_LEN   = 16'(MAX_PACKET_BYTES);
   // The first attribute needs more than two declared bytes past the header.
   localparam logic [15:0]      FIRST_ATTR_LIMIT = 16'(HDR_BYTES + 2);

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_TYPE   = 3'd1,
      PH_LEN    = 3'd2,
      PH_EMIT   = 3'd3,
      PH_SKIP   = 3'd4,
      PH_DONE   = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ST_FOUND      = 3'd0,
      ST_NOT_FOUND  = 3'd1,
      ST_TOO_SHORT  = 3'd2,
      ST_BAD_LENGTH = 3'd3,
      ST_MALFORMED  = 3'd4,
      ST_TOO_LARGE  = 3'd5
   } status_type;

   typedef enum logic {
      CSR_WANTED_TYPE    = 1'b0,
      CSR_VALUE_CAPACITY = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0]  value_byte;
      logic        is_status;
      logic [2:0]  status;
      logic [7:0]  value_length;
      logic [7:0]  packet_code;
      logic [7:0]  packet_identifier;
      logic [15:0] declared_length;
   } rsp_type;

   // Words produced by one accepted byte: none, one, or a value word then a status word.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

// ----- hdl/ras_core.sv -----
// Per-byte scan engine: header capture, attribute walk and status generation.
// Depends on ras_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ras_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  ras_pkg::req_type   req,
   input  logic [7:0]         wanted_type,
   input  logic [8:0]         value_capacity,
   output ras_pkg::push_type  push
);
   import ras_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       code_ff, code_in;
   logic [7:0]       ident_ff, ident_in;
   logic [15:0]      len_ff, len_in;
   phase_type        phase_ff, phase_in;
   logic [7:0]       atype_ff, atype_in;
   logic [7:0]       left_ff, left_in;
   status_type       result_ff, result_in;
   logic [7:0]       found_ff, found_in;

   logic [7:0]       b;
   logic [POS_W-1:0] remain;
   logic [POS_W:0]   next_limit;
   logic             more_attr;
   logic [7:0]       vlen;
   logic [7:0]       left_dec;
   logic             emit;
   status_type       st;
   rsp_type          value_word, status_word;

   assign b = req.data_byte;
   // Declared bytes from the type byte (one before the current length byte) onward.
   assign remain     = POS_W'(len_ff) - (pos_ff - POS_W'(1));
   // Another attribute fits if more than two declared bytes follow the current byte.
   assign next_limit = (POS_W+1)'(pos_ff) + (POS_W+1)'(3);
   assign more_attr  = (POS_W+1)'(len_ff) > next_limit;
   assign vlen       = b - 8'd2;
   assign left_dec   = left_ff - 8'd1;

   // Next state.
   always_comb begin
      pos_in    = (pos_ff == POS_MAX) ? pos_ff : pos_ff + POS_W'(1);
      code_in   = code_ff;
      ident_in  = ident_ff;
      len_in    = len_ff;
      phase_in  = phase_ff;
      atype_in  = atype_ff;
      left_in   = left_ff;
      result_in = result_ff;
      found_in  = found_ff;
      unique case (phase_ff)
         PH_HEADER: begin
            if (pos_ff == POS_W'(0)) begin
               code_in = b;
            end
            if (pos_ff == POS_W'(1)) begin
               ident_in = b;
            end
            if (pos_ff == POS_W'(2)) begin
               len_in = {b, 8'h00};
            end
            if (pos_ff == POS_W'(3)) begin
               len_in = {len_ff[15:8], b};
            end
            if (pos_ff >= HDR_LAST) begin
               if (len_ff > MAX_LEN) begin
                  phase_in = PH_DONE;
               end else if (len_ff > FIRST_ATTR_LIMIT) begin
                  phase_in = PH_TYPE;
               end else begin
                  phase_in  = PH_DONE;
                  result_in = ST_NOT_FOUND;
               end
            end
         end
         PH_TYPE: begin
            atype_in = b;
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            if (b < 8'd2 || POS_W'(b) > remain) begin
               phase_in  = PH_DONE;
               result_in = ST_MALFORMED;
            end else if (atype_ff == wanted_type) begin
               if ({1'b0, vlen} + 9'd1 > value_capacity) begin
                  phase_in  = PH_DONE;
                  result_in = ST_TOO_LARGE;
               end else begin
                  found_in = vlen;
                  if (vlen == 8'd0) begin
                     phase_in  = PH_DONE;
                     result_in = ST_FOUND;
                  end else begin
                     left_in  = vlen;
                     phase_in = PH_EMIT;
                  end
               end
            end else begin
               left_in = vlen;
               if (vlen != 8'd0) begin
                  phase_in = PH_SKIP;
               end else if (more_attr) begin
                  phase_in = PH_TYPE;
               end else begin
                  phase_in  = PH_DONE;
                  result_in = ST_NOT_FOUND;
               end
            end
         end
         PH_EMIT: begin
            left_in = left_dec;
            if (left_dec == 8'd0) begin
               phase_in  = PH_DONE;
               result_in = ST_FOUND;
            end
         end
         PH_SKIP: begin
            left_in = left_dec;
            if (left_dec == 8'd0) begin
               if (more_attr) begin
                  phase_in = PH_TYPE;
               end else begin
                  phase_in  = PH_DONE;
                  result_in = ST_NOT_FOUND;
               end
            end
         end
         PH_DONE: begin
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      emit = (phase_ff == PH_EMIT);
      priority if (pos_in < HDR_COUNT) begin
         st = ST_TOO_SHORT;
      end else if (len_in > MAX_LEN || POS_W'(len_in) > pos_in) begin
         st = ST_BAD_LENGTH;
      end else begin
         st = result_in;
      end

      value_word.value_byte        = b;
      value_word.is_status         = 1'b0;
      value_word.status            = ST_FOUND;
      value_word.value_length      = found_in;
      value_word.packet_code       = code_in;
      value_word.packet_identifier = ident_in;
      value_word.declared_length   = len_in;

      status_word.value_byte        = 8'd0;
      status_word.is_status         = 1'b1;
      status_word.status            = st;
      status_word.value_length      = (st == ST_FOUND) ? found_in : 8'd0;
      status_word.packet_code       = code_in;
      status_word.packet_identifier = ident_in;
      status_word.declared_length   = len_in;

      push.first  = emit ? value_word : status_word;
      push.second = status_word;
      if (accept) begin
         push.count = {1'b0, emit} + {1'b0, req.last};
      end else begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req.last)) begin
         pos_ff    <= '0;
         code_ff   <= '0;
         ident_ff  <= '0;
         len_ff    <= '0;
         phase_ff  <= PH_HEADER;
         atype_ff  <= '0;
         left_ff   <= '0;
         result_ff <= ST_NOT_FOUND;
         found_ff  <= '0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         code_ff   <= code_in;
         ident_ff  <= ident_in;
         len_ff    <= len_in;
         phase_ff  <= phase_in;
         atype_ff  <= atype_in;
         left_ff   <= left_in;
         result_ff <= result_in;
         found_ff  <= found_in;
      end
   end

   `RAS_ASSERT_NXT(a_last_restarts, accept && req.last,
      pos_ff == '0 && phase_ff == PH_HEADER, "run state not cleared after last byte")
   `RAS_ASSERT_NXT(a_done_sticks, accept && !req.last && phase_ff == PH_DONE,
      phase_ff == PH_DONE, "scan left the done phase before the last byte")
   `RAS_ASSERT_IMP(a_emit_bounded, phase_ff == PH_EMIT,
      left_ff != 8'd0 && left_ff <= found_ff, "value byte count out of range")

endmodule

// ----- hdl/ras_oq.sv -----
// Result queue: takes up to two words, delivers one per cycle, each unless stalled.
// Depends on ras_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ras_oq (
   input  logic              clock,
   input  logic              reset,
   input  ras_pkg::push_type push,
   output logic              in_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ras_pkg::rsp_type  rsp_data
);
   import ras_pkg::*;

   localparam int PTR_W = $clog2(OQ_DEPTH);
   localparam int CNT_W = $clog2(OQ_DEPTH + 1);

   rsp_type          mem_ff [OQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_ptr_next;
   logic             pop;

   // Room for two words is kept so a value word and its status word always fit.
   assign in_stall    = count_ff > CNT_W'(OQ_DEPTH - 2);
   assign rsp_valid   = count_ff != '0;
   assign rsp_data    = mem_ff[rd_ptr_ff];
   assign pop         = rsp_valid && !rsp_stall;
   assign wr_ptr_next = wr_ptr_ff + PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `RAS_ASSERT(a_oq_bound, count_ff <= CNT_W'(OQ_DEPTH), "result queue overflow")
   `RAS_ASSERT_IMP(a_no_push_stalled, in_stall, push.count == 2'd0,
      "word pushed while the input is stalled")
   `RAS_ASSERT_IMP(a_push_range, 1'b1, push.count != 2'd3, "impossible push count")

endmodule

// ----- hdl/radius_attribute_scanner.sv -----
// RADIUS attribute scanner top level: ports, configuration registers and wiring.
// Depends on ras_pkg, ras_core and ras_oq.
//
// Usage: packet bytes enter one word per cycle on req_ (data_byte, last); a word is
// taken at a rising edge with req_valid high and req_stall low. Bytes 0..19 are the
// header; later bytes inside the declared length are walked as attributes. Value bytes
// of the first attribute whose type equals wanted_type leave on rsp_ as value words,
// and the byte marked last yields one status word that ends the run. If the last byte
// is also a value byte, its value word goes out first, then the status word.
// Latency: with the result queue empty, the first word a byte produces is on rsp_ the
// cycle after the byte is taken; queued words leave first, one per cycle if not stalled.
// Throughput: one byte per cycle; the scan state updates once per byte and a four-word
// result queue decouples the receiver, stalling req_ only when fewer than two queue
// slots are free. The output drains one word per cycle while rsp_stall is low.
// Configuration: csr_ writes (index 0 wanted_type, 1 value_capacity) are always ready
// and must be made only while the block is idle.
// Reset (synchronous, active high) empties the queue, restarts the run and restores
// wanted_type to 2 and value_capacity to 129. While rsp_stall is high, the pending
// word holds and bytes keep being taken until the queue is nearly full.

module radius_attribute_scanner (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ras_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ras_pkg::rsp_type       rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  ras_pkg::csr_index_type csr_index,
   input  logic [8:0]             csr_wdata
);
   import ras_pkg::*;

   logic [7:0] wanted_type_ff;
   logic [8:0] value_capacity_ff;
   logic       accept;
   push_type   push;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_type_ff    <= 8'd2;
         value_capacity_ff <= 9'd129;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WANTED_TYPE:    wanted_type_ff    <= csr_wdata[7:0];
            CSR_VALUE_CAPACITY: value_capacity_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   ras_core u_core (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req            (req_data),
      .wanted_type    (wanted_type_ff),
      .value_capacity (value_capacity_ff),
      .push           (push)
   );

   ras_oq u_oq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .in_stall  (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
